/* rtl/srrip_pkg.sv */
package srrip_pkg;

    localparam int MODE_W    = 2;
    localparam int SET_IN_W  = 11;
    localparam int WAY_IN_W  = 4;
    localparam int VICTIM_W  = 4;

    localparam logic [MODE_W-1:0] MODE_VICTIM = 2'd0;
    localparam logic [MODE_W-1:0] MODE_HIT    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FILL   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_NONE   = 2'd3;

    // Control that travels with a word from the address stage to the update stage.
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              way_ok;
    } upd_ctl_t;

endpackage

/* rtl/srrip_rrpv_mem.sv */
module srrip_rrpv_mem #(
    parameter int DEPTH  = 2048,
    parameter int ADDR_W = 11,
    parameter int DATA_W = 48
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/srrip_row_update.sv */
module srrip_row_update #(
    parameter int NUM_WAYS = 16,
    parameter int MAX_PRED = 7,
    parameter int PRED_W   = 3,
    parameter int WAY_W    = 4
) (
    input  logic [NUM_WAYS*PRED_W-1:0] row_in,
    input  srrip_pkg::upd_ctl_t        ctl,
    input  logic [WAY_W-1:0]           way,
    output logic [NUM_WAYS*PRED_W-1:0] row_out,
    output logic                       wr_en,
    output logic [WAY_W-1:0]           victim
);

    import srrip_pkg::*;

    localparam int LEAF = 1 << WAY_W;

    logic [PRED_W-1:0] node [2*LEAF];
    logic [PRED_W-1:0] top;
    logic [PRED_W-1:0] lift;

    // Row maximum through a balanced tree of compares.
    always_comb
    begin
        for (int i = 0; i < LEAF; i++)
        begin
            node[LEAF+i] = '0;
        end
        for (int i = 0; i < NUM_WAYS; i++)
        begin
            node[LEAF+i] = row_in[i*PRED_W +: PRED_W];
        end
        node[0] = '0;
        for (int i = LEAF - 1; i >= 1; i--)
        begin
            node[i] = (node[2*i] > node[2*i+1]) ? node[2*i] : node[2*i+1];
        end
    end

    assign top  = node[1];
    assign lift = PRED_W'(MAX_PRED) - top;

    always_comb
    begin
        victim  = '0;
        row_out = row_in;
        wr_en   = 1'b0;
        unique case (ctl.mode)
            MODE_VICTIM:
            begin
                // Aging lifts every way equally, so the first way at the
                // row maximum is the first way at the top after aging.
                for (int w = NUM_WAYS - 1; w >= 0; w--)
                begin
                    if (row_in[w*PRED_W +: PRED_W] == top)
                    begin
                        victim = WAY_W'(w);
                    end
                end
                for (int w = 0; w < NUM_WAYS; w++)
                begin
                    row_out[w*PRED_W +: PRED_W] = row_in[w*PRED_W +: PRED_W] + lift;
                end
                wr_en = (top != PRED_W'(MAX_PRED));
            end
            MODE_HIT:
            begin
                row_out[way*PRED_W +: PRED_W] = '0;
                wr_en = ctl.way_ok;
            end
            MODE_FILL:
            begin
                row_out[way*PRED_W +: PRED_W] = PRED_W'(MAX_PRED - 1);
                wr_en = ctl.way_ok;
            end
            MODE_NONE:
            begin
                wr_en = 1'b0;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

endmodule

/* rtl/srrip_replacement_policy.sv */
// SRRIP replacement state for a set-associative cache, one prediction value
// per way, kept as one memory row per set.
// Input channel (in_valid / in_stall) carries a word of mode, set_index and
// way_index: a victim request, a hit update or a fill update. Set indexes at
// or above NUM_SETS wrap around; hits and fills to a way at or above NUM_WAYS
// are dropped, as is the unused mode code.
// Output channel (out_valid / out_stall) carries victim_way, one word for each
// victim request and none for hits and fills.
// An item passes the address stage, where the set is reduced to a row address
// and the row read is issued, then the update stage, where the row is updated,
// written back and the victim registered. The block takes a new item while the
// last one is in the update stage but not while it is in the address stage;
// the read of the next row waits for the write of the previous one.
// After reset every row is written to the maximum value, one row per cycle,
// from row 0 to row NUM_SETS-1, and in_stall stays high during that time.
// A victim word held by out_stall stays in the output register; the block
// still takes items and stalls the input once a victim request reaches the
// update stage and needs the output register.
module srrip_replacement_policy #(
    parameter int NUM_SETS = 2048,
    parameter int NUM_WAYS = 16,
    parameter int MAX_PRED = 7
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [srrip_pkg::MODE_W-1:0]     mode,
    input  logic [srrip_pkg::SET_IN_W-1:0]   set_index,
    input  logic [srrip_pkg::WAY_IN_W-1:0]   way_index,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [srrip_pkg::VICTIM_W-1:0]   victim_way
);

    import srrip_pkg::*;

    localparam int PRED_W = $clog2(MAX_PRED + 1);
    localparam int WAY_W  = $clog2(NUM_WAYS);
    localparam int ADDR_W = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int ROW_W  = NUM_WAYS * PRED_W;

    // Exact quotient of an 11-bit set by NUM_SETS through a rounded-up reciprocal.
    localparam int unsigned SHIFT = SET_IN_W + $clog2(NUM_SETS);
    localparam int unsigned RECIP = ((1 << SHIFT) + NUM_SETS - 1) / NUM_SETS;
    localparam int PROD_W = SET_IN_W + $clog2(RECIP + 1);
    localparam int MUL_W  = SET_IN_W + 17;

    logic                  clr_active_reg, clr_active_next;
    logic [ADDR_W-1:0]     clr_addr_reg, clr_addr_next;

    logic                  a_valid_reg, a_valid_next;
    logic [MODE_W-1:0]     a_mode_reg;
    logic [SET_IN_W-1:0]   a_set_reg;
    logic [WAY_IN_W-1:0]   a_way_reg;
    logic [SET_IN_W-1:0]   a_q_reg;

    logic                  b_valid_reg, b_valid_next;
    upd_ctl_t              b_ctl_reg;
    logic [WAY_W-1:0]      b_way_reg;
    logic [ADDR_W-1:0]     b_addr_reg;

    logic                  out_valid_reg, out_valid_next;
    logic [VICTIM_W-1:0]   victim_reg;

    logic                  in_take;
    logic                  a_move;
    logic                  b_done;
    logic [PROD_W-1:0]     prod;
    logic [SET_IN_W-1:0]   q_in;
    logic [MUL_W-1:0]      qn;
    logic [SET_IN_W-1:0]   rem;
    logic [ADDR_W-1:0]     a_addr;
    upd_ctl_t              a_ctl;

    logic [ROW_W-1:0]      rd_row;
    logic [ROW_W-1:0]      upd_row;
    logic                  upd_wr_en;
    logic [WAY_W-1:0]      upd_victim;
    logic                  mem_wr_en;
    logic [ADDR_W-1:0]     mem_wr_addr;
    logic [ROW_W-1:0]      mem_wr_data;

    assign b_done  = b_valid_reg &&
                     ((b_ctl_reg.mode != MODE_VICTIM) || !out_valid_reg || !out_stall);
    assign in_stall = clr_active_reg || a_valid_reg || (b_valid_reg && !b_done);
    assign in_take  = in_valid && !in_stall;
    // The row read waits until the update stage is empty, so it never races a write.
    assign a_move   = a_valid_reg && !b_valid_reg;

    always_comb
    begin
        prod = PROD_W'(set_index) * PROD_W'(RECIP);
        q_in = SET_IN_W'(prod >> SHIFT);
    end

    always_comb
    begin
        qn          = MUL_W'(a_q_reg) * MUL_W'(NUM_SETS);
        rem         = a_set_reg - SET_IN_W'(qn);
        a_addr      = ADDR_W'(rem);
        a_ctl.mode  = a_mode_reg;
        a_ctl.way_ok = (32'(a_way_reg) < NUM_WAYS);
    end

    always_comb
    begin
        clr_active_next = clr_active_reg;
        clr_addr_next   = clr_addr_reg;
        if (clr_active_reg)
        begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == ADDR_W'(NUM_SETS - 1))
            begin
                clr_active_next = 1'b0;
            end
        end

        a_valid_next = in_take || (a_valid_reg && !a_move);
        b_valid_next = a_move || (b_valid_reg && !b_done);

        out_valid_next = out_valid_reg && out_stall;
        if (b_done && (b_ctl_reg.mode == MODE_VICTIM))
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
            a_valid_reg    <= 1'b0;
            b_valid_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            clr_active_reg <= clr_active_next;
            clr_addr_reg   <= clr_addr_next;
            a_valid_reg    <= a_valid_next;
            b_valid_reg    <= b_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            a_mode_reg <= mode;
            a_set_reg  <= set_index;
            a_way_reg  <= way_index;
            a_q_reg    <= q_in;
        end
        if (a_move)
        begin
            b_ctl_reg  <= a_ctl;
            b_way_reg  <= WAY_W'(a_way_reg);
            b_addr_reg <= a_addr;
        end
        if (b_done && (b_ctl_reg.mode == MODE_VICTIM))
        begin
            victim_reg <= VICTIM_W'(upd_victim);
        end
    end

    always_comb
    begin
        if (clr_active_reg)
        begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = clr_addr_reg;
            mem_wr_data = {NUM_WAYS{PRED_W'(MAX_PRED)}};
        end
        else
        begin
            mem_wr_en   = b_done && upd_wr_en;
            mem_wr_addr = b_addr_reg;
            mem_wr_data = upd_row;
        end
    end

    srrip_rrpv_mem #(
        .DEPTH  (NUM_SETS),
        .ADDR_W (ADDR_W),
        .DATA_W (ROW_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (a_move),
        .rd_addr (a_addr),
        .rd_data (rd_row)
    );

    srrip_row_update #(
        .NUM_WAYS (NUM_WAYS),
        .MAX_PRED (MAX_PRED),
        .PRED_W   (PRED_W),
        .WAY_W    (WAY_W)
    ) u_update (
        .row_in  (rd_row),
        .ctl     (b_ctl_reg),
        .way     (b_way_reg),
        .row_out (upd_row),
        .wr_en   (upd_wr_en),
        .victim  (upd_victim)
    );

    assign out_valid  = out_valid_reg;
    assign victim_way = victim_reg;

endmodule
